// ===== rtl/chop_pkg.sv =====
package chop_pkg;

    // Parse phase within one datagram
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_OPTHDR  = 2'd1,
        PH_VALUE   = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // Byte classification codes
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_OPTHDR  = 2'd1;
    localparam logic [1:0] CLS_VALUE   = 2'd2;
    localparam logic [1:0] CLS_PAYLOAD = 2'd3;

    // Status codes
    localparam logic [1:0] ST_FINE    = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // Option numbers that are checked
    localparam logic [7:0] OPT_CONTENT_TYPE = 8'd1;
    localparam logic [7:0] OPT_MAX_AGE      = 8'd2;
    localparam logic [7:0] OPT_URI_PORT     = 8'd7;
    localparam logic [7:0] OPT_OBSERVE      = 8'd10;
    localparam logic [7:0] OPT_ACCEPT       = 8'd12;
    localparam logic [7:0] OPT_BLOCK2       = 8'd17;
    localparam logic [7:0] OPT_BLOCK1       = 8'd19;

    localparam logic [3:0] NIBBLE_EXT = 4'hf;
    localparam logic [8:0] EXT_BASE   = 9'd15;
    localparam logic [8:0] CT_ABSENT  = 9'd256;

    // Parser state, one datagram's worth
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hdr_pos;
        logic [3:0]  opts_left;
        logic [7:0]  opt_num;
        logic [8:0]  val_len;
        logic [8:0]  val_left;
        logic [23:0] acc;       // last three value bytes
        logic [25:0] hdr;       // type[25:24] code[23:16] tid[15:0]
        logic [24:0] blk;       // present[24] index[23:4] more[3] szx[2:0]
        logic [8:0]  ct;
        logic [1:0]  status;
        logic        ext_pending;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_HEADER,
        hdr_pos:     2'd0,
        opts_left:   4'd0,
        opt_num:     8'd0,
        val_len:     9'd0,
        val_left:    9'd0,
        acc:         24'd0,
        hdr:         26'd0,
        blk:         25'd0,
        ct:          CT_ABSENT,
        status:      ST_FINE,
        ext_pending: 1'b0
    };

    // One result transaction
    typedef struct packed {
        logic [1:0]  byte_class;
        logic [7:0]  option_number;
        logic [8:0]  option_length;
        logic [1:0]  message_type;
        logic [7:0]  method_or_response;
        logic [15:0] transaction_id;
        logic        block_present;
        logic [19:0] block_index;
        logic        block_more;
        logic [2:0]  block_size_exponent;
        logic [8:0]  payload_content_type;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== rtl/chop_if.sv =====
// Byte input channel
interface chop_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       end_of_message;

    modport source (output valid, output message_byte, output end_of_message, input ready);
    modport sink   (input valid, input message_byte, input end_of_message, output ready);
endinterface

// Parse result channel
interface chop_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_class;
    logic [7:0]  option_number;
    logic [8:0]  option_length;
    logic [1:0]  message_type;
    logic [7:0]  method_or_response;
    logic [15:0] transaction_id;
    logic        block_present;
    logic [19:0] block_index;
    logic        block_more;
    logic [2:0]  block_size_exponent;
    logic [8:0]  payload_content_type;
    logic [1:0]  status;

    modport source (
        output valid, input ready,
        output byte_class, output option_number, output option_length,
        output message_type, output method_or_response, output transaction_id,
        output block_present, output block_index, output block_more,
        output block_size_exponent, output payload_content_type, output status
    );
    modport sink (
        input valid, output ready,
        input byte_class, input option_number, input option_length,
        input message_type, input method_or_response, input transaction_id,
        input block_present, input block_index, input block_more,
        input block_size_exponent, input payload_content_type, input status
    );
endinterface

// ===== rtl/coap_header_option_parser_unit.sv =====
// Parses an early-draft CoAP datagram one byte per transaction, with
// end_of_message on the final byte, and returns one result transaction per
// byte: the byte's class plus the header fields, running option number and
// length, last block option, content type and status as they stand after
// that byte. A byte is taken every cycle while input ready is high; its result
// appears in the cycle after it is accepted, from a single result register
// fed by the per-byte parse logic, and input ready drops only while that
// register is full and the result sink stalls. After the marked last byte
// the parser is back at the start of a header.
module coap_header_option_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chop_byte_if.sink     i_byte,
    chop_result_if.source o_result
);

    chop_pkg::t_state  r_state;
    chop_pkg::t_state  n_state;
    chop_pkg::t_result step_result;
    logic              can_load;
    logic              accept;

    assign i_byte.ready = can_load;
    assign accept       = i_byte.valid && can_load;

    // Per-byte parse logic
    chop_step u_step (
        .i_state  (r_state),
        .i_byte   (i_byte.message_byte),
        .i_last   (i_byte.end_of_message),
        .o_next   (n_state),
        .o_result (step_result)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chop_pkg::STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    chop_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (step_result),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

    // Last byte returns the parser to the header start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_byte.end_of_message |=>
            r_state.phase == chop_pkg::PH_HEADER && r_state.hdr_pos == 2'd0)
        else $error("parser not restarted after last byte");

    // Value phase always has bytes left to take
    a_value_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == chop_pkg::PH_VALUE |-> r_state.val_left != 9'd0)
        else $error("value phase with no bytes left");

    // Extended length pending only while reading option headers
    a_ext_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ext_pending |-> r_state.phase == chop_pkg::PH_OPTHDR)
        else $error("extended length pending outside option header");

    // Header bytes come only before any option was parsed
    a_hdr_opt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.byte_class == chop_pkg::CLS_HEADER |->
            o_result.option_number == 8'd0 && o_result.block_present == 1'b0)
        else $error("header byte after option state");

endmodule

// ===== rtl/chop_step.sv =====
module chop_step (
    input  chop_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output chop_pkg::t_state  o_next,
    output chop_pkg::t_result o_result
);

    chop_pkg::t_state n;
    logic             start;
    logic [8:0]       start_len;
    logic             fin;
    logic             bad;
    logic [1:0]       cls;
    logic [3:0]       left_dec;

    // Per-byte state update
    always_comb begin
        n         = i_state;
        start     = 1'b0;
        start_len = 9'd0;
        fin       = 1'b0;
        bad       = 1'b0;
        cls       = chop_pkg::CLS_HEADER;
        left_dec  = 4'd0;

        case (i_state.phase)
            chop_pkg::PH_HEADER: begin
                cls = chop_pkg::CLS_HEADER;
                case (i_state.hdr_pos)
                    2'd0: begin
                        n.hdr[25:24] = i_byte[5:4];
                        n.opts_left  = i_byte[3:0];
                    end
                    2'd1: n.hdr[23:16] = i_byte;
                    2'd2: n.hdr[15:8]  = i_byte;
                    default: begin
                        n.hdr[7:0] = i_byte;
                        n.phase    = (i_state.opts_left != 4'd0) ?
                                     chop_pkg::PH_OPTHDR : chop_pkg::PH_PAYLOAD;
                    end
                endcase
                n.hdr_pos = i_state.hdr_pos + 2'd1;
            end
            chop_pkg::PH_OPTHDR: begin
                cls = chop_pkg::CLS_OPTHDR;
                if (i_state.ext_pending) begin
                    start     = 1'b1;
                    start_len = chop_pkg::EXT_BASE + {1'b0, i_byte};
                end else begin
                    n.opt_num = i_state.opt_num + {4'd0, i_byte[7:4]};
                    if (i_byte[3:0] == chop_pkg::NIBBLE_EXT) begin
                        n.ext_pending = 1'b1;
                        n.val_len     = chop_pkg::EXT_BASE;
                    end else begin
                        start     = 1'b1;
                        start_len = {5'd0, i_byte[3:0]};
                    end
                end
            end
            chop_pkg::PH_VALUE: begin
                cls        = chop_pkg::CLS_VALUE;
                n.acc      = {i_state.acc[15:0], i_byte};
                n.val_left = i_state.val_left - 9'd1;
                fin        = (i_state.val_left == 9'd1);
            end
            default: begin
                cls = chop_pkg::CLS_PAYLOAD;
            end
        endcase

        // Begin an option value
        if (start) begin
            n.ext_pending = 1'b0;
            n.val_len     = start_len;
            n.val_left    = start_len;
            n.acc         = 24'd0;
            if (start_len == 9'd0) begin
                fin = 1'b1;
            end else begin
                n.phase = chop_pkg::PH_VALUE;
            end
        end

        // Option complete: check length and record known options
        if (fin) begin
            case (n.opt_num)
                chop_pkg::OPT_CONTENT_TYPE: begin
                    if (n.val_len != 9'd1) begin
                        bad = 1'b1;
                    end else begin
                        n.ct = {1'b0, n.acc[7:0]};
                    end
                end
                chop_pkg::OPT_MAX_AGE, chop_pkg::OPT_OBSERVE: begin
                    bad = (n.val_len > 9'd4);
                end
                chop_pkg::OPT_URI_PORT: begin
                    bad = (n.val_len > 9'd2);
                end
                chop_pkg::OPT_ACCEPT: begin
                    bad = (n.val_len != 9'd1);
                end
                chop_pkg::OPT_BLOCK2, chop_pkg::OPT_BLOCK1: begin
                    if (n.val_len >= 9'd1 && n.val_len <= 9'd3) begin
                        n.blk = {1'b1, n.acc};
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b0;
                end
            endcase
            if (bad && n.status == chop_pkg::ST_FINE) begin
                n.status = chop_pkg::ST_BAD_LEN;
            end
            left_dec    = n.opts_left - 4'd1;
            n.opts_left = left_dec;
            n.phase     = (left_dec != 4'd0) ? chop_pkg::PH_OPTHDR : chop_pkg::PH_PAYLOAD;
        end
    end

    // Result fields reflect the state after this byte
    always_comb begin
        o_result.byte_class           = cls;
        o_result.option_number        = n.opt_num;
        o_result.option_length        = n.val_len;
        o_result.message_type         = n.hdr[25:24];
        o_result.method_or_response   = n.hdr[23:16];
        o_result.transaction_id       = n.hdr[15:0];
        o_result.block_present        = n.blk[24];
        o_result.block_index          = n.blk[23:4];
        o_result.block_more           = n.blk[3];
        o_result.block_size_exponent  = n.blk[2:0];
        o_result.payload_content_type = n.ct;
        o_result.status               = (i_last && n.phase != chop_pkg::PH_PAYLOAD) ?
                                        chop_pkg::ST_TRUNC : n.status;
    end

    // End of datagram restarts the parser
    assign o_next = i_last ? chop_pkg::STATE_RESET : n;

endmodule

// ===== rtl/chop_out_reg.sv =====
module chop_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  chop_pkg::t_result i_result,
    output logic              o_can_load,
    chop_result_if.source     o_result
);

    logic              r_valid;
    logic              n_valid;
    chop_pkg::t_result r_data;

    // Free when empty or being drained this cycle
    assign o_can_load = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_result.valid                = r_valid;
    assign o_result.byte_class           = r_data.byte_class;
    assign o_result.option_number        = r_data.option_number;
    assign o_result.option_length        = r_data.option_length;
    assign o_result.message_type         = r_data.message_type;
    assign o_result.method_or_response   = r_data.method_or_response;
    assign o_result.transaction_id       = r_data.transaction_id;
    assign o_result.block_present        = r_data.block_present;
    assign o_result.block_index          = r_data.block_index;
    assign o_result.block_more           = r_data.block_more;
    assign o_result.block_size_exponent  = r_data.block_size_exponent;
    assign o_result.payload_content_type = r_data.payload_content_type;
    assign o_result.status               = r_data.status;

endmodule

// ===== sim/coap_header_option_parser_unit_tb.sv =====
import chop_pkg::*;

// Tracks the parse of each datagram byte and checks the result transactions in order
class coap_parse_scoreboard;

    // Parser state, one datagram's worth
    t_phase      parse_phase;
    bit [1:0]    hdr_pos;
    bit [3:0]    opts_left;
    bit [7:0]    opt_number;
    bit [8:0]    opt_len;
    bit [8:0]    value_left;
    bit [23:0]   value_bytes;      // last three value bytes
    bit          ext_pending;
    bit [1:0]    msg_type;
    bit [7:0]    msg_code;
    bit [15:0]   msg_tid;
    bit          blk_present;
    bit [19:0]   blk_index;
    bit          blk_more;
    bit [2:0]    blk_szx;
    bit [8:0]    content_type;
    bit [1:0]    parse_status;

    t_result     pending_results[$];
    int unsigned errors;

    function new();
        errors = 0;
        clear_message();
    endfunction

    function void clear_message();
        parse_phase  = PH_HEADER;
        hdr_pos      = '0;
        opts_left    = '0;
        opt_number   = '0;
        opt_len      = '0;
        value_left   = '0;
        value_bytes  = '0;
        ext_pending  = 1'b0;
        msg_type     = '0;
        msg_code     = '0;
        msg_tid      = '0;
        blk_present  = 1'b0;
        blk_index    = '0;
        blk_more     = 1'b0;
        blk_szx      = '0;
        content_type = CT_ABSENT;
        parse_status = ST_FINE;
    endfunction

    // First bad length wins; it never overrides an earlier status
    function void flag_bad_length();
        if (parse_status == ST_FINE) begin
            parse_status = ST_BAD_LEN;
        end
    endfunction

    // Option complete: apply its value, then move on
    function void close_option();
        case (opt_number)
            OPT_CONTENT_TYPE: begin
                if (opt_len != 9'd1) begin
                    flag_bad_length();
                end else begin
                    content_type = {1'b0, value_bytes[7:0]};
                end
            end
            OPT_MAX_AGE, OPT_OBSERVE: begin
                if (opt_len > 9'd4) flag_bad_length();
            end
            OPT_URI_PORT: begin
                if (opt_len > 9'd2) flag_bad_length();
            end
            OPT_ACCEPT: begin
                if (opt_len != 9'd1) flag_bad_length();
            end
            OPT_BLOCK2, OPT_BLOCK1: begin
                if (opt_len >= 9'd1 && opt_len <= 9'd3) begin
                    blk_present = 1'b1;
                    blk_index   = value_bytes[23:4];
                    blk_more    = value_bytes[3];
                    blk_szx     = value_bytes[2:0];
                end else begin
                    flag_bad_length();
                end
            end
            default: ;
        endcase
        opts_left = opts_left - 4'd1;
        if (opts_left != 0) begin
            parse_phase = PH_OPTHDR;
        end else begin
            parse_phase = PH_PAYLOAD;
        end
    endfunction

    function void open_value(bit [8:0] len);
        ext_pending = 1'b0;
        opt_len     = len;
        value_left  = len;
        value_bytes = '0;
        if (len == 0) begin
            close_option();
        end else begin
            parse_phase = PH_VALUE;
        end
    endfunction

    // Accepted byte: advance the parse and queue the result it should give
    function void note_byte(bit [7:0] b, bit last);
        t_result   res;
        bit [1:0]  cls;
        cls = CLS_HEADER;
        case (parse_phase)
            PH_HEADER: begin
                cls = CLS_HEADER;
                case (hdr_pos)
                    2'd0: begin
                        msg_type  = b[5:4];
                        opts_left = b[3:0];
                    end
                    2'd1: msg_code = b;
                    2'd2: msg_tid[15:8] = b;
                    default: begin
                        msg_tid[7:0] = b;
                        if (opts_left != 0) begin
                            parse_phase = PH_OPTHDR;
                        end else begin
                            parse_phase = PH_PAYLOAD;
                        end
                    end
                endcase
                hdr_pos = hdr_pos + 2'd1;
            end
            PH_OPTHDR: begin
                cls = CLS_OPTHDR;
                if (ext_pending) begin
                    open_value(EXT_BASE + {1'b0, b});
                end else begin
                    opt_number = opt_number + {4'd0, b[7:4]};
                    if (b[3:0] == NIBBLE_EXT) begin
                        ext_pending = 1'b1;
                        opt_len     = EXT_BASE;
                    end else begin
                        open_value({5'd0, b[3:0]});
                    end
                end
            end
            PH_VALUE: begin
                cls = CLS_VALUE;
                value_bytes = {value_bytes[15:0], b};
                value_left  = value_left - 9'd1;
                if (value_left == 0) close_option();
            end
            default: cls = CLS_PAYLOAD;
        endcase

        res.byte_class           = cls;
        res.option_number        = opt_number;
        res.option_length        = opt_len;
        res.message_type         = msg_type;
        res.method_or_response   = msg_code;
        res.transaction_id       = msg_tid;
        res.block_present        = blk_present;
        res.block_index          = blk_index;
        res.block_more           = blk_more;
        res.block_size_exponent  = blk_szx;
        res.payload_content_type = content_type;
        res.status               = parse_status;
        // end mark anywhere short of the payload means a cut-off message
        if (last && parse_phase != PH_PAYLOAD) res.status = ST_TRUNC;
        pending_results.push_back(res);

        if (last) clear_message();
    endfunction

    function void compare_field(string field, logic [19:0] want, logic [19:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Result transaction: compare against the oldest queued result
    function void check_result(t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result transaction with no byte outstanding");
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("byte_class", want.byte_class, got.byte_class);
        compare_field("option_number", want.option_number, got.option_number);
        compare_field("option_length", want.option_length, got.option_length);
        compare_field("message_type", want.message_type, got.message_type);
        compare_field("method_or_response", want.method_or_response,
                      got.method_or_response);
        compare_field("transaction_id", want.transaction_id, got.transaction_id);
        compare_field("block_present", want.block_present, got.block_present);
        compare_field("block_index", want.block_index, got.block_index);
        compare_field("block_more", want.block_more, got.block_more);
        compare_field("block_size_exponent", want.block_size_exponent,
                      got.block_size_exponent);
        compare_field("payload_content_type", want.payload_content_type,
                      got.payload_content_type);
        compare_field("status", want.status, got.status);
    endfunction

endclass

module coap_header_option_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Options that the parser checks, used to steer the random deltas
    localparam bit [7:0] HOT_OPTS [7] = '{OPT_CONTENT_TYPE, OPT_MAX_AGE, OPT_URI_PORT,
                                          OPT_OBSERVE, OPT_ACCEPT, OPT_BLOCK2, OPT_BLOCK1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    chop_byte_if   byte_ch ();
    chop_result_if result_ch ();

    coap_header_option_parser_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    coap_parse_scoreboard parse_sb = new();

    bit [7:0]    msg_bytes[$];
    int unsigned sent_bytes = 0;
    int unsigned cycle_count = 0;
    bit          send_quiet = 1'b0;
    bit          sink_quiet = 1'b0;

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One byte transaction, after a random idle gap
    task automatic send_byte(input bit [7:0] b, input bit last);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.message_byte   <= b;
        byte_ch.end_of_message <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        parse_sb.note_byte(b, last);
        sent_bytes++;
    endtask

    // Sends msg_bytes up to last_idx, with the end mark on that byte
    task automatic send_message(input int unsigned last_idx);
        for (int unsigned i = 0; i <= last_idx; i++) begin
            send_byte(msg_bytes[i], i == last_idx);
        end
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        if (parse_sb.pending_results.size() != 0) begin
            byte_ch.valid <= 1'b0;
            while (parse_sb.pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // Well-formed datagram: header, options steered at the checked numbers, payload
    task automatic build_wellformed();
        int unsigned n_opts;
        int unsigned cur;
        int unsigned delta;
        int unsigned len;
        int unsigned ext;
        int unsigned n_pay;
        bit [7:0]    target;
        msg_bytes.delete();
        n_opts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        msg_bytes.push_back({4'($urandom_range(0, 15)), 4'(n_opts)});
        repeat (3) msg_bytes.push_back(8'($urandom));
        cur = 0;
        for (int unsigned i = 0; i < n_opts; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                target = HOT_OPTS[$urandom_range(0, 6)];
                if (target >= cur) begin
                    delta = (target - cur > 15) ? 15 : target - cur;
                end else begin
                    delta = $urandom_range(0, 3);
                end
            end else begin
                delta = $urandom_range(0, 15);
            end
            cur += delta;
            // mostly legal lengths, sometimes anything
            case (8'(cur))
                OPT_CONTENT_TYPE, OPT_ACCEPT: len = 1;
                OPT_MAX_AGE, OPT_OBSERVE:     len = $urandom_range(0, 4);
                OPT_URI_PORT:                 len = $urandom_range(0, 2);
                OPT_BLOCK2, OPT_BLOCK1:       len = $urandom_range(1, 3);
                default:                      len = $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 14);
            if ($urandom_range(0, 9) == 0) begin
                // extended length, rarely a long one
                ext = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 10);
                msg_bytes.push_back({4'(delta), NIBBLE_EXT});
                msg_bytes.push_back(8'(ext));
                len = 15 + ext;
            end else begin
                msg_bytes.push_back({4'(delta), 4'(len)});
            end
            repeat (len) msg_bytes.push_back(8'($urandom));
        end
        n_pay = $urandom_range(0, 6);
        repeat (n_pay) msg_bytes.push_back(8'($urandom));
    endtask

    // Result side: random stalls, capture and check each transaction
    initial begin
        int unsigned stall;
        t_result     got;
        result_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = sink_quiet ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 29) == 0) sink_quiet = !sink_quiet;
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            got.byte_class           = result_ch.byte_class;
            got.option_number        = result_ch.option_number;
            got.option_length        = result_ch.option_length;
            got.message_type         = result_ch.message_type;
            got.method_or_response   = result_ch.method_or_response;
            got.transaction_id       = result_ch.transaction_id;
            got.block_present        = result_ch.block_present;
            got.block_index          = result_ch.block_index;
            got.block_more           = result_ch.block_more;
            got.block_size_exponent  = result_ch.block_size_exponent;
            got.payload_content_type = result_ch.payload_content_type;
            got.status               = result_ch.status;
            parse_sb.check_result(got);
        end
    end

    // Stimulus
    initial begin
        int unsigned kind;
        int unsigned n;
        i_rst_n                <= 1'b0;
        byte_ch.valid          <= 1'b0;
        byte_ch.message_byte   <= 8'h00;
        byte_ch.end_of_message <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header only, no options, ends right after the transaction id
        msg_bytes = '{8'h40, 8'h01, 8'h12, 8'h34};
        send_message(msg_bytes.size() - 1);

        // Content-Type, Accept with a bad length, three-byte Block1, payload
        msg_bytes = '{8'h73, 8'hff, 8'hff, 8'hff,
                      8'h11, 8'h00,
                      8'hb2, 8'h05, 8'h06,
                      8'h73, 8'hab, 8'hcd, 8'hef,
                      8'hff, 8'h00};
        send_message(msg_bytes.size() - 1);

        // Cut off inside the header
        msg_bytes = '{8'h50, 8'h00};
        send_message(msg_bytes.size() - 1);

        // Max-Age with an extended length, cut off inside its value
        msg_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h2f, 8'h00, 8'haa};
        send_message(msg_bytes.size() - 1);

        drain_results();

        // Random datagrams: mostly well-formed, some cut short, some noise
        while (sent_bytes < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                msg_bytes.delete();
                n = $urandom_range(1, 20);
                repeat (n) msg_bytes.push_back(8'($urandom));
                send_message(n - 1);
            end else begin
                build_wellformed();
                if (kind < 6) begin
                    send_message($urandom_range(0, msg_bytes.size() - 1));
                end else begin
                    send_message(msg_bytes.size() - 1);
                end
            end
            if ($urandom_range(0, 24) == 0) drain_results();
        end

        // Wind down: let all results come back, then a few quiet cycles
        byte_ch.valid <= 1'b0;
        while (parse_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (parse_sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
